// File: src/srarq_pkg.sv
// Shared types and constants for the selective-repeat ARQ sender.
package srarq_pkg;

    localparam int DEF_WINDOW_DEPTH = 64;

    localparam int SEQ_W  = 16;
    localparam int WIN_W  = 7;     // window size, up to 64 slots
    localparam int WBITS_W = 3;
    localparam int RTO_W  = 15;
    localparam int SLOTO_W = 6;

    localparam logic [WBITS_W-1:0] RST_WINDOW_BITS = 3'd3;
    localparam logic [RTO_W-1:0]   RST_RTO_TICKS   = 15'd20;

    localparam logic CFG_WINDOW_BITS = 1'b0;
    localparam logic CFG_RTO_TICKS   = 1'b1;

    localparam logic [1:0] OP_NEW   = 2'd0;
    localparam logic [1:0] OP_REPLY = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;   // unused, ignored

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_NAK   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;  // other frame types, ignored
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SEND   = 2'd1;
    localparam logic [1:0] ACT_RETX   = 2'd2;
    localparam logic [1:0] ACT_REFUSE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_EXEC,
        ST_CLEAR,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// File: src/srarq_mod_unit.sv
// Bit-serial remainder unit: sequence number modulo window size.
module srarq_mod_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [srarq_pkg::SEQ_W-1:0]    i_value,
    input  logic [srarq_pkg::WIN_W-1:0]    i_div,
    output logic                           o_done,
    output logic [srarq_pkg::WIN_W-1:0]    o_rem
);

    logic                         r_busy;
    logic                         r_done;
    logic [3:0]                   r_cnt;
    logic [srarq_pkg::SEQ_W-1:0]  r_val;
    logic [srarq_pkg::WIN_W-1:0]  r_rem;
    logic [srarq_pkg::WIN_W:0]    trial;
    logic [srarq_pkg::WIN_W:0]    n_rem;

    // one restoring step per cycle, MSB first
    always_comb begin
        trial = {r_rem, r_val[srarq_pkg::SEQ_W-1]};
        if (trial >= {1'b0, i_div}) begin
            n_rem = trial - {1'b0, i_div};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[srarq_pkg::SEQ_W-2:0], 1'b0};
            r_rem <= n_rem[srarq_pkg::WIN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: src/selective_repeat_arq_sender.sv
// Selective-repeat ARQ sender window control: top level.
//
// Input channel (i_in_valid / o_in_stall) carries one event: a new-frame
// request, a received ACK/NAK with its checksum flag, or a time tick.
// Every event yields exactly one result transfer on the output channel
// (o_out_valid / i_out_stall): action, sequence number, slot, and the window
// base and next sequence number after the event.
// Every accepted event passes through the remainder unit, an ignored event
// skips it, an ACK also clears each slot that the window slides past, and
// a tick also scans the timers of the outstanding slots up to the first
// timed-out frame. The time an event takes is set by the
// 16-step serial remainder unit (seq mod window) and by the walk over the
// slot timers, one timer memory read a cycle.
// One event is in work at a time; o_in_stall is high from acceptance until
// its result has been moved to the output register, so the next transfer
// comes in the cycle after that at the earliest.
// Reset clears base, next sequence, tick count and all pending bits, and
// loads window_bits 3 and rto_ticks 20. Timer stamps are not cleared.
// A stalled result holds in the output register; the next event can be
// accepted meanwhile but finishes only once the output register frees up.
// Config writes (i_cfg_we) are only legal while no event is in work.
module selective_repeat_arq_sender #(
    parameter int WINDOW_DEPTH = srarq_pkg::DEF_WINDOW_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config port
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_idx,
    input  logic [srarq_pkg::RTO_W-1:0]      i_cfg_data,
    // event input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_opcode,
    input  logic [1:0]                       i_reply_kind,
    input  logic [srarq_pkg::SEQ_W-1:0]      i_reply_seq,
    input  logic                             i_check_ok,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_action,
    output logic [srarq_pkg::SEQ_W-1:0]      o_out_seq,
    output logic [srarq_pkg::SLOTO_W-1:0]    o_out_slot,
    output logic [srarq_pkg::SEQ_W-1:0]      o_base_seq,
    output logic [srarq_pkg::SEQ_W-1:0]      o_next_out_seq
);

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SW = srarq_pkg::SEQ_W;
    localparam int WW = srarq_pkg::WIN_W;

    // ---------------- state ----------------
    srarq_pkg::t_state r_state, n_state;

    logic [srarq_pkg::WBITS_W-1:0] r_wbits;
    logic [srarq_pkg::RTO_W-1:0]   r_rto;

    logic [SW-1:0] r_base;
    logic [SW-1:0] r_next;
    logic [SW-1:0] r_now;
    logic [WINDOW_DEPTH-1:0] r_pending;
    logic [SW-1:0] r_stamp_mem [WINDOW_DEPTH];
    logic [SW-1:0] r_stamp_q;

    // latched event
    logic [1:0]    r_op;
    logic [1:0]    r_kind;
    logic [SW-1:0] r_rseq;
    logic          r_ok;

    // sequencer working registers
    logic [WW-1:0] r_slot;      // current slot of the walk
    logic [WW-1:0] r_k;         // slots visited
    logic [WW-1:0] r_n;         // slots to visit
    logic [SW-1:0] r_seq;       // sequence number at r_slot
    logic          r_chk_vld;   // a timer read is in flight
    logic [WW-1:0] r_chk_slot;
    logic [SW-1:0] r_chk_seq;

    // pending result
    logic [1:0]    r_res_act;
    logic [SW-1:0] r_res_seq;
    logic [WW-1:0] r_res_slot;

    // output register
    logic                         r_out_vld;
    logic [1:0]                   r_out_act;
    logic [SW-1:0]                r_out_seq;
    logic [srarq_pkg::SLOTO_W-1:0] r_out_slot;
    logic [SW-1:0]                r_out_base;
    logic [SW-1:0]                r_out_next;

    // ---------------- derived values ----------------
    logic [srarq_pkg::WBITS_W-1:0] m_eff;
    logic [WW-1:0]  w_raw;
    logic [WW-1:0]  w;
    logic [SW-1:0]  outstanding;
    logic [SW-1:0]  seq_dist;
    logic           ack_ok;
    logic           nak_ok;
    logic [WW-1:0]  slot_inc;
    logic [srarq_pkg::RTO_W-1:0] rto_eff;
    logic [SW-1:0]  age;
    logic           scan_hit;
    logic           scan_more;

    always_comb begin
        m_eff = (r_wbits == '0) ? srarq_pkg::WBITS_W'(1) : r_wbits;
        w_raw = WW'(1) << (m_eff - srarq_pkg::WBITS_W'(1));
        if (9'(w_raw) > 9'(WINDOW_DEPTH)) begin
            w = WW'(WINDOW_DEPTH);
        end else begin
            w = w_raw;
        end
    end

    assign outstanding = r_next - r_base;
    assign seq_dist    = r_rseq - r_base;
    assign ack_ok      = r_ok && (r_kind == srarq_pkg::KIND_ACK) &&
                         (seq_dist != '0) && (seq_dist <= outstanding);
    assign nak_ok      = r_ok && (r_kind == srarq_pkg::KIND_NAK) && (seq_dist < outstanding);
    assign slot_inc    = (r_slot + WW'(1) == w) ? '0 : r_slot + WW'(1);
    assign rto_eff     = (r_rto == '0) ? srarq_pkg::RTO_W'(1) : r_rto;
    assign age         = r_now - r_stamp_q;
    assign scan_hit    = r_chk_vld && r_pending[SLOT_W'(r_chk_slot)] &&
                         (age >= SW'(rto_eff));
    assign scan_more   = (r_k < r_n);

    // ---------------- remainder unit ----------------
    logic          mod_start;
    logic [SW-1:0] mod_value;
    logic          mod_done;
    logic [WW-1:0] mod_rem;

    srarq_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (mod_value),
        .i_div   (w),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // ---------------- next state ----------------
    logic out_free;
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            srarq_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = srarq_pkg::ST_DECODE;
            end
            srarq_pkg::ST_DECODE: begin
                case (r_op)
                    srarq_pkg::OP_NEW:   n_state = srarq_pkg::ST_MOD;
                    srarq_pkg::OP_TICK:  n_state = srarq_pkg::ST_MOD;
                    srarq_pkg::OP_REPLY: n_state = (ack_ok || nak_ok) ?
                                                   srarq_pkg::ST_MOD : srarq_pkg::ST_FIN;
                    default:             n_state = srarq_pkg::ST_FIN;
                endcase
            end
            srarq_pkg::ST_MOD: begin
                if (mod_done) n_state = srarq_pkg::ST_EXEC;
            end
            srarq_pkg::ST_EXEC: begin
                if (r_op == srarq_pkg::OP_TICK) begin
                    n_state = srarq_pkg::ST_SCAN;
                end else if (r_op == srarq_pkg::OP_REPLY && ack_ok) begin
                    n_state = srarq_pkg::ST_CLEAR;
                end else begin
                    n_state = srarq_pkg::ST_FIN;
                end
            end
            srarq_pkg::ST_CLEAR: begin
                if (!scan_more) n_state = srarq_pkg::ST_FIN;
            end
            srarq_pkg::ST_SCAN: begin
                if (scan_hit || (!scan_more && !r_chk_vld)) n_state = srarq_pkg::ST_FIN;
            end
            srarq_pkg::ST_FIN: begin
                if (out_free) n_state = srarq_pkg::ST_IDLE;
            end
            default: n_state = srarq_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    logic          out_load;
    logic          stamp_we;
    logic [WW-1:0] stamp_waddr;

    always_comb begin
        o_in_stall  = (r_state != srarq_pkg::ST_IDLE);
        mod_start   = (r_state == srarq_pkg::ST_DECODE);
        mod_value   = (r_op == srarq_pkg::OP_NEW) ? r_next :
                      (r_op == srarq_pkg::OP_TICK) ? r_base :
                      (ack_ok ? r_base : r_rseq);
        out_load    = (r_state == srarq_pkg::ST_FIN) && out_free;
        stamp_we    = 1'b0;
        stamp_waddr = mod_rem;
        case (r_state)
            srarq_pkg::ST_EXEC: begin
                if (r_op == srarq_pkg::OP_NEW) begin
                    stamp_we = (outstanding < SW'(w));
                end else if (r_op == srarq_pkg::OP_REPLY) begin
                    stamp_we = nak_ok;
                end
            end
            srarq_pkg::ST_SCAN: begin
                stamp_we    = scan_hit;
                stamp_waddr = r_chk_slot;
            end
            default: begin
                stamp_we = 1'b0;
            end
        endcase
    end

    // ---------------- timer memory ----------------
    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            r_stamp_mem[SLOT_W'(stamp_waddr)] <= r_now;
        end
        r_stamp_q <= r_stamp_mem[SLOT_W'(r_slot)];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srarq_pkg::ST_IDLE;
            r_wbits   <= srarq_pkg::RST_WINDOW_BITS;
            r_rto     <= srarq_pkg::RST_RTO_TICKS;
            r_base    <= '0;
            r_next    <= '0;
            r_now     <= '0;
            r_pending <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == srarq_pkg::CFG_WINDOW_BITS) begin
                    r_wbits <= i_cfg_data[srarq_pkg::WBITS_W-1:0];
                end else begin
                    r_rto <= i_cfg_data;
                end
            end

            case (r_state)
                srarq_pkg::ST_DECODE: begin
                    if (r_op == srarq_pkg::OP_TICK) r_now <= r_now + SW'(1);
                end
                srarq_pkg::ST_EXEC: begin
                    r_chk_vld <= 1'b0;
                    if (r_op == srarq_pkg::OP_NEW && outstanding < SW'(w)) begin
                        r_pending[SLOT_W'(mod_rem)] <= 1'b1;
                        r_next <= r_next + SW'(1);
                    end else if (r_op == srarq_pkg::OP_REPLY && nak_ok) begin
                        r_pending[SLOT_W'(mod_rem)] <= 1'b1;
                    end
                end
                srarq_pkg::ST_CLEAR: begin
                    if (scan_more) begin
                        r_pending[SLOT_W'(r_slot)] <= 1'b0;
                    end else begin
                        r_base <= r_rseq;
                    end
                end
                srarq_pkg::ST_SCAN: begin
                    // read issued this cycle is checked next cycle
                    r_chk_vld <= scan_more && !scan_hit;
                end
                default: begin
                    r_chk_vld <= 1'b0;
                end
            endcase

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            srarq_pkg::ST_IDLE: begin
                r_op   <= i_opcode;
                r_kind <= i_reply_kind;
                r_rseq <= i_reply_seq;
                r_ok   <= i_check_ok;
            end
            srarq_pkg::ST_DECODE: begin
                r_res_act  <= srarq_pkg::ACT_NONE;
                r_res_seq  <= '0;
                r_res_slot <= '0;
            end
            srarq_pkg::ST_EXEC: begin
                r_slot <= mod_rem;
                r_seq  <= r_base;
                r_k    <= '0;
                if (r_op == srarq_pkg::OP_NEW) begin
                    r_res_act  <= (outstanding < SW'(w)) ?
                                  srarq_pkg::ACT_SEND : srarq_pkg::ACT_REFUSE;
                    r_res_seq  <= r_next;
                    r_res_slot <= mod_rem;
                end else if (r_op == srarq_pkg::OP_REPLY) begin
                    if (nak_ok) begin
                        r_res_act  <= srarq_pkg::ACT_RETX;
                        r_res_seq  <= r_rseq;
                        r_res_slot <= mod_rem;
                    end
                    r_n <= (seq_dist < SW'(w)) ? WW'(seq_dist) : w;
                end else begin
                    r_n <= (outstanding < SW'(w)) ? WW'(outstanding) : w;
                end
            end
            srarq_pkg::ST_CLEAR: begin
                if (scan_more) begin
                    r_slot <= slot_inc;
                    r_k    <= r_k + WW'(1);
                end
            end
            srarq_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    r_res_act  <= srarq_pkg::ACT_RETX;
                    r_res_seq  <= r_chk_seq;
                    r_res_slot <= r_chk_slot;
                end else if (scan_more) begin
                    r_chk_slot <= r_slot;
                    r_chk_seq  <= r_seq;
                    r_slot     <= slot_inc;
                    r_seq      <= r_seq + SW'(1);
                    r_k        <= r_k + WW'(1);
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase

        if (out_load) begin
            r_out_act  <= r_res_act;
            r_out_seq  <= r_res_seq;
            r_out_slot <= srarq_pkg::SLOTO_W'(r_res_slot);
            r_out_base <= r_base;
            r_out_next <= r_next;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_action       = r_out_act;
    assign o_out_seq      = r_out_seq;
    assign o_out_slot     = r_out_slot;
    assign o_base_seq     = r_out_base;
    assign o_next_out_seq = r_out_next;

endmodule
